// File: sv/sha256_stream_hash_assert.svh
// Assertion macros for the SHA-256 stream hash checker.
// No dependencies.
`ifndef SHA256_STREAM_HASH_ASSERT_SVH
`define SHA256_STREAM_HASH_ASSERT_SVH
// check a property each clock edge, off during reset
`define SHA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that a signal is stable while stalled
`define SHA_HOLD(label, clk, rst_n, vld, stl, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && stl) |=> (vld && $stable(sig))) else $error(msg);
`endif

// File: sv/sha256_pkg.sv
// Types and constants for the SHA-256 stream hash.
// No dependencies.
package sha256_pkg;
	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  valid_bytes;
		logic        msg_first;
		logic        msg_last;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_last;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_FETCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic step;
	} sched_ctl_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] h;
		unique case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	localparam logic [7:0] PAD_BYTE = 8'h80;
	// block word that holds byte 56, where the bit length starts
	localparam logic [3:0] LEN_WORD = 4'd14;
endpackage

// File: sv/sha256_sched.sv
// Message schedule: sixteen-word sliding window that yields W[t] each round.
// Depends on sha256_pkg.
module sha256_sched (
	input  logic                   clk,
	input  sha256_pkg::sched_ctl_t ctl,
	input  logic [511:0]           block,
	output logic [31:0]            w
);
	logic [31:0] win_q [16];
	logic [31:0] s0, s1, nw;

	always_comb begin
		s0 = sha256_pkg::rotr(win_q[1], 7) ^ sha256_pkg::rotr(win_q[1], 18)
			^ (win_q[1] >> 3);
		s1 = sha256_pkg::rotr(win_q[14], 17) ^ sha256_pkg::rotr(win_q[14], 19)
			^ (win_q[14] >> 10);
		nw = win_q[0] + s0 + win_q[9] + s1;
		w  = win_q[0];
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int i = 0; i < 16; i++) win_q[i] <= block[511 - 32*i -: 32];
		end else if (ctl.step) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= nw;
		end
	end
endmodule

// File: sv/sha256_stream_hash.sv
// SHA-256 over a stream of big-endian words; eight digest beats per message.
// Input words are taken one per cycle while the block fills; each full block then
// holds the input while the hash memory is read into the working variables, 64
// rounds run, and the sums are added and written back. A last item fills the rest
// of its block with pad words in the pad state and takes one or two compressions;
// the digest is then read out beat by beat through a fetch and an emit state, holding on any output stall.
// Depends on sha256_pkg and sha256_sched.
module sha256_stream_hash (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  sha256_pkg::in_beat_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output sha256_pkg::out_beat_t out_data
);
	sha256_pkg::state_t state_q, state_d;
	logic [31:0] blk_q [16];
	logic [31:0] hmem [8];
	logic [31:0] hrd_s1;
	logic [2:0]  hidx_s1;
	logic [7:0]  hinit_q;
	logic [3:0]  fill_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic [3:0]  cnt_q;
	logic [2:0]  oidx_q;
	logic        padding_q, need80_q, lenhi_q, final_q;
	logic [31:0] va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q;
	logic [511:0] blk_flat;
	logic [31:0] w;
	sha256_pkg::sched_ctl_t sctl;
	logic        accept, hwe;
	logic [2:0]  hraddr;
	logic [31:0] hword, hsum, mword, pword, t1, t2;
	logic [2:0]  nb;
	logic [3:0]  base_fill;
	logic [63:0] base_len, bits;

	assign accept = in_valid && !in_stall;

	always_comb begin
		for (int i = 0; i < 16; i++) blk_flat[511 - 32*i -: 32] = blk_q[i];
		sctl.start = (state_q == sha256_pkg::ST_LOAD) && (cnt_q == 4'd0);
		sctl.step  = (state_q == sha256_pkg::ST_ROUND);
	end

	sha256_sched u_sched (.clk(clk), .ctl(sctl), .block(blk_flat), .w(w));

	// item word, with the pad byte placed after the valid bytes of a short last item
	always_comb begin
		nb = 3'd4;
		if (in_data.msg_last && in_data.valid_bytes < 3'd4) nb = in_data.valid_bytes;
		unique case (nb)
			3'd0: mword = {sha256_pkg::PAD_BYTE, 24'h0};
			3'd1: mword = {in_data.data_word[31:24], sha256_pkg::PAD_BYTE, 16'h0};
			3'd2: mword = {in_data.data_word[31:16], sha256_pkg::PAD_BYTE, 8'h0};
			3'd3: mword = {in_data.data_word[31:8], sha256_pkg::PAD_BYTE};
			default: mword = in_data.data_word;
		endcase
		base_fill = in_data.msg_first ? 4'd0 : fill_q;
		base_len  = in_data.msg_first ? 64'd0 : len_q;
		bits = {len_q[60:0], 3'b000};
		if (need80_q) pword = {sha256_pkg::PAD_BYTE, 24'h0};
		else if (fill_q == sha256_pkg::LEN_WORD) pword = bits[63:32];
		else if (lenhi_q) pword = bits[31:0];
		else pword = 32'h0;
	end

	// hash memory: hinit marks words still at their initial value
	always_comb begin
		if (state_q == sha256_pkg::ST_FETCH || state_q == sha256_pkg::ST_EMIT)
			hraddr = oidx_q;
		else
			hraddr = cnt_q[2:0];
		hword = hinit_q[hidx_s1] ? sha256_pkg::init_hash(hidx_s1) : hrd_s1;
		hsum  = hword + va_q;
		hwe   = (state_q == sha256_pkg::ST_ADD) && (cnt_q != 4'd0);
	end

	always_ff @(posedge clk) begin
		hrd_s1  <= hmem[hraddr];
		hidx_s1 <= hraddr;
		if (hwe) hmem[hidx_s1] <= hsum;
	end

	always_ff @(posedge clk) begin
		if (accept) blk_q[base_fill] <= mword;
		else if (state_q == sha256_pkg::ST_PAD) blk_q[fill_q] <= pword;
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (base_fill == 4'd15) state_d = sha256_pkg::ST_LOAD;
					else if (in_data.msg_last) state_d = sha256_pkg::ST_PAD;
				end
			end
			sha256_pkg::ST_PAD: if (fill_q == 4'd15) state_d = sha256_pkg::ST_LOAD;
			sha256_pkg::ST_LOAD: if (cnt_q == 4'd8) state_d = sha256_pkg::ST_ROUND;
			sha256_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = sha256_pkg::ST_ADD;
			sha256_pkg::ST_ADD: begin
				if (cnt_q == 4'd8) begin
					if (final_q) state_d = sha256_pkg::ST_FETCH;
					else if (padding_q) state_d = sha256_pkg::ST_PAD;
					else state_d = sha256_pkg::ST_IDLE;
				end
			end
			sha256_pkg::ST_FETCH: state_d = sha256_pkg::ST_EMIT;
			sha256_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall)
					state_d = (oidx_q == 3'd7) ? sha256_pkg::ST_IDLE : sha256_pkg::ST_FETCH;
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sha256_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hinit_q <= 8'hff;
			fill_q <= 4'd0;
			len_q <= 64'd0;
			rnd_q <= 6'd0;
			cnt_q <= 4'd0;
			oidx_q <= 3'd0;
			padding_q <= 1'b0;
			need80_q <= 1'b0;
			lenhi_q <= 1'b0;
			final_q <= 1'b0;
		end else begin
			case (state_q)
				sha256_pkg::ST_IDLE: if (accept) begin
					if (in_data.msg_first) hinit_q <= 8'hff;
					len_q <= base_len + {61'd0, nb};
					fill_q <= base_fill + 4'd1;
					padding_q <= in_data.msg_last;
					need80_q <= in_data.msg_last && (nb == 3'd4);
					lenhi_q <= 1'b0;
					final_q <= 1'b0;
					cnt_q <= 4'd0;
				end
				sha256_pkg::ST_PAD: begin
					fill_q <= fill_q + 4'd1;
					need80_q <= 1'b0;
					lenhi_q <= !need80_q && (fill_q == sha256_pkg::LEN_WORD);
					final_q <= lenhi_q;
					cnt_q <= 4'd0;
				end
				sha256_pkg::ST_LOAD: begin
					cnt_q <= (cnt_q == 4'd8) ? 4'd0 : cnt_q + 4'd1;
					rnd_q <= 6'd0;
				end
				sha256_pkg::ST_ROUND: rnd_q <= rnd_q + 6'd1;
				sha256_pkg::ST_ADD: begin
					cnt_q <= (cnt_q == 4'd8) ? 4'd0 : cnt_q + 4'd1;
					if (cnt_q != 4'd0) hinit_q[hidx_s1] <= 1'b0;
					oidx_q <= 3'd0;
				end
				sha256_pkg::ST_EMIT: if (!out_stall) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						hinit_q <= 8'hff;
						fill_q <= 4'd0;
						len_q <= 64'd0;
						padding_q <= 1'b0;
						final_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		t1 = vh_q + (sha256_pkg::rotr(ve_q, 6) ^ sha256_pkg::rotr(ve_q, 11)
			^ sha256_pkg::rotr(ve_q, 25)) + ((ve_q & vf_q) ^ (~ve_q & vg_q))
			+ sha256_pkg::round_k(rnd_q) + w;
		t2 = (sha256_pkg::rotr(va_q, 2) ^ sha256_pkg::rotr(va_q, 13)
			^ sha256_pkg::rotr(va_q, 22)) + ((va_q & vb_q) ^ (va_q & vc_q) ^ (vb_q & vc_q));
	end

	// shift hash words in on load, sums out on add; one round per cycle between
	always_ff @(posedge clk) begin
		if ((state_q == sha256_pkg::ST_LOAD || state_q == sha256_pkg::ST_ADD)
			&& cnt_q != 4'd0) begin
			va_q <= vb_q; vb_q <= vc_q; vc_q <= vd_q; vd_q <= ve_q;
			ve_q <= vf_q; vf_q <= vg_q; vg_q <= vh_q;
			vh_q <= (state_q == sha256_pkg::ST_LOAD) ? hword : hsum;
		end else if (state_q == sha256_pkg::ST_ROUND) begin
			vh_q <= vg_q; vg_q <= vf_q; vf_q <= ve_q; ve_q <= vd_q + t1;
			vd_q <= vc_q; vc_q <= vb_q; vb_q <= va_q; va_q <= t1 + t2;
		end
	end

	always_comb begin
		out_data.digest_word = hword;
		out_data.word_index  = oidx_q;
		out_data.digest_last = (oidx_q == 3'd7);
	end
endmodule

// File: sv/sha256_stream_hash_chk.sv
// Port checker for the SHA-256 stream hash, bound to the top level.
// Depends on sha256_pkg and sha256_stream_hash_assert.svh.
`include "sha256_stream_hash_assert.svh"
module sha256_stream_hash_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input sha256_pkg::out_beat_t out_data
);
	`SHA_HOLD(a_out_hold, clk, arst_n, out_valid, out_stall, out_data, "output beat changed")
	`SHA_ASSERT(a_no_overlap, clk, arst_n, out_valid |-> in_stall, "input taken while emitting")
	`SHA_ASSERT(a_idx_step, clk, arst_n,
		(out_valid && !out_stall && !out_data.digest_last) |=>
		(!out_valid || out_data.word_index == $past(out_data.word_index) + 3'd1),
		"digest index skipped")
endmodule

bind sha256_stream_hash sha256_stream_hash_chk u_chk (.clk(clk), .arst_n(arst_n),
	.in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .out_data(out_data));

// File: test/sha256_stream_hash_checker.sv
// Checker for the SHA-256 stream hash: watches both channels, keeps its own digest model,
// and compares each output beat with the oldest predicted digest word.
// Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_stream_hash_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  sha256_pkg::in_beat_t  in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  sha256_pkg::out_beat_t out_data,
	output int                    fail_count,
	output int                    pending
);
	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
	localparam logic [31:0] IV_TAB [8] = '{
		32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
		32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

	logic [31:0] chain [8];
	logic [31:0] blk [16];
	logic [6:0]  fill;
	logic [63:0] msg_len;
	sha256_pkg::out_beat_t digest_q [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15],7) ^ ror(w[i-15],18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2],17) ^ ror(w[i-2],19) ^ (w[i-2] >> 10));
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4],6) ^ ror(v[4],11) ^ ror(v[4],25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
			t2 = (ror(v[0],2) ^ ror(v[0],13) ^ ror(v[0],22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
	endtask

	task automatic push_byte(input logic [7:0] b);
		int sh;
		sh = 24 - 8 * fill[1:0];
		blk[fill[5:2]] = (blk[fill[5:2]] & ~(32'hff << sh)) | ({24'd0, b} << sh);
		fill = fill + 7'd1;
		if (fill >= 7'd64) begin
			compress_block();
			fill = '0;
		end
	endtask

	task automatic restart_digest();
		for (int i = 0; i < 8; i++) chain[i] = IV_TAB[i];
		fill = '0;
		msg_len = '0;
	endtask

	task automatic absorb_beat(input sha256_pkg::in_beat_t b);
		int nb;
		logic [63:0] bits;
		sha256_pkg::out_beat_t o;
		if (b.msg_first) restart_digest();
		nb = (!b.msg_last || b.valid_bytes > 3'd4) ? 4 : int'(b.valid_bytes);
		for (int i = 0; i < nb; i++) push_byte(b.data_word[31-8*i -: 8]);
		msg_len = msg_len + 64'(nb);
		if (b.msg_last) begin
			bits = msg_len << 3;
			push_byte(8'h80);
			while (fill != 7'd56) push_byte(8'h00);
			for (int i = 0; i < 8; i++) push_byte(bits[63-8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				o.digest_word = chain[i];
				o.word_index = 3'(i);
				o.digest_last = (i == 7);
				digest_q.push_back(o);
			end
			restart_digest();
		end
	endtask

	always @(posedge clk) begin
		sha256_pkg::out_beat_t e;
		if (!arst_n) begin
			restart_digest();
			digest_q.delete();
			fail_count = 0;
		end else begin
			if (in_valid && !in_stall) absorb_beat(in_data);
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected digest beat %h", out_data);
				end else begin
					e = digest_q.pop_front();
					if (e.digest_word !== out_data.digest_word
						|| e.word_index !== out_data.word_index
						|| e.digest_last !== out_data.digest_last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
								e.digest_word, e.word_index, e.digest_last,
								out_data.digest_word, out_data.word_index,
								out_data.digest_last);
					end
				end
			end
		end
		pending = digest_q.size();
	end
endmodule

// File: test/tb_top.sv
// Testbench top for the SHA-256 stream hash: drives message beats with random gaps
// and output stalls, and reports the checker's verdict. Depends on sha256_pkg, sha256_stream_hash and the checker.
`timescale 1ns / 1ps
module tb_top;
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	sha256_pkg::in_beat_t  in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	sha256_pkg::out_beat_t out_data;
	int                    fail_count;
	int                    pending;
	bit                    calm = 1'b0;

	always #6 clk = ~clk;

	sha256_stream_hash dut (.*);

	sha256_stream_hash_checker chk (.*);

	always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 25);

	task automatic send_beat(input logic [31:0] w, input logic [2:0] vb,
			input logic f, input logic l);
		while (!calm && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_word: w, valid_bytes: vb, msg_first: f, msg_last: l};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_message(input int words, input logic f, input logic [2:0] vb);
		for (int i = 0; i < words; i++)
			send_beat($urandom, (i == words - 1) ? vb : 3'($urandom),
				f && (i == 0), i == words - 1);
	endtask

	initial begin
		int sent;
		int n;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// known short messages and edge lengths
		send_beat(32'h61626300, 3'd3, 1'b1, 1'b1);
		send_beat(32'h00000000, 3'd0, 1'b1, 1'b1);
		send_beat(32'hffffffff, 3'd4, 1'b0, 1'b1);
		send_beat(32'hffffffff, 3'd7, 1'b1, 1'b1);
		send_beat(32'h12345678, 3'd5, 1'b0, 1'b1);
		send_message(14, 1'b1, 3'd4);
		send_message(14, 1'b1, 3'd3);
		send_message(16, 1'b0, 3'd0);
		send_beat(32'hdeadbeef, 3'd2, 1'b0, 1'b0);
		send_beat(32'hcafef00d, 3'd1, 1'b1, 1'b1);
		sent = 51;
		while (sent < 460) begin
			calm = (sent > 200 && sent < 260);
			n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 18);
			send_message(n, 1'($urandom_range(1)), 3'($urandom));
			sent += n;
		end
		in_valid <= 1'b0;
		calm = 1'b1;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end
endmodule
